// ===== design/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] a_real;
        logic [31:0] a_imag;
        logic [31:0] b_real;
        logic [31:0] b_imag;
    } t_in_item;

    typedef struct packed {
        logic [31:0] res_real;
        logic [31:0] res_imag;
        logic        overflow;
        logic        div_by_zero;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/complex_arith_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fraction bits). One item enters per clock unless a
// finished result waits at the output. The pipeline depth is set by the
// restoring divider, which resolves one quotient bit
// per stage over DATA_WIDTH + 1 stages, after five stages of input capture,
// products, sums, magnitudes and divider setup, and before the output register.
// The whole pipeline holds while a finished result waits at the output, so
// items are never lost or repeated.
// Products and quotients truncate toward zero; parts out of range saturate and
// set overflow. A divide by zero gives zero parts and sets div_by_zero.
module complex_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  cau_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cau_pkg::t_out_item  o_out_item
);

    localparam int DW  = DATA_WIDTH;
    localparam int MW  = 2 * DATA_WIDTH;
    localparam int QW  = DATA_WIDTH + 1;
    localparam int DDW = MW + FRAC_BITS;
    localparam int NST = QW + 6;

    localparam logic signed [DW:0]   SMAX = {2'b00, {(DW - 1){1'b1}}};
    localparam logic signed [DW:0]   SMIN = {2'b11, {(DW - 1){1'b0}}};
    localparam logic        [MW-1:0] HALF = MW'(1) << (DW - 1);

    typedef struct packed {
        logic          ov;
        logic [DW-1:0] v;
    } t_sat;

    typedef struct packed {
        logic [1:0]    func;
        t_sat          as_re;
        t_sat          as_im;
        t_sat          mu_re;
        t_sat          mu_im;
        logic          neg_re;
        logic          neg_im;
        logic          dz;
        logic          dov_re;
        logic          dov_im;
        logic [MW-1:0] den;
    } t_side;

    function automatic t_sat sat_add(input logic signed [DW:0] x);
        t_sat r;
        r.ov = 1'b0;
        r.v  = x[DW-1:0];
        if (x > SMAX) begin
            r.ov = 1'b1;
            r.v  = SMAX[DW-1:0];
        end else if (x < SMIN) begin
            r.ov = 1'b1;
            r.v  = SMIN[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_mag(input logic neg, input logic [MW-1:0] mag);
        t_sat          r;
        logic [MW-1:0] lim;
        logic [MW-1:0] m;
        lim  = neg ? HALF : HALF - MW'(1);
        m    = mag;
        r.ov = 1'b0;
        if (mag > lim) begin
            m    = lim;
            r.ov = 1'b1;
        end
        r.v = neg ? (DW'(0) - m[DW-1:0]) : m[DW-1:0];
        return r;
    endfunction

    logic           en;
    logic [NST-1:0] r_vld;

    assign en          = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Stage 1: operand capture, add and subtract.
    logic signed [DW-1:0] r1_ar, r1_ai, r1_br, r1_bi;
    logic [1:0]           r1_func;
    t_sat                 r1_as_re, r1_as_im;
    logic signed [DW:0]   n1_x_re, n1_x_im;

    always_comb begin
        logic signed [DW:0] ar, ai, br, bi;
        ar = (DW + 1)'($signed(i_in_item.a_real[DW-1:0]));
        ai = (DW + 1)'($signed(i_in_item.a_imag[DW-1:0]));
        br = (DW + 1)'($signed(i_in_item.b_real[DW-1:0]));
        bi = (DW + 1)'($signed(i_in_item.b_imag[DW-1:0]));
        if (i_in_item.func == cau_pkg::FN_SUB) begin
            n1_x_re = ar - br;
            n1_x_im = ai - bi;
        end else begin
            n1_x_re = ar + br;
            n1_x_im = ai + bi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_func  <= i_in_item.func;
            r1_ar    <= $signed(i_in_item.a_real[DW-1:0]);
            r1_ai    <= $signed(i_in_item.a_imag[DW-1:0]);
            r1_br    <= $signed(i_in_item.b_real[DW-1:0]);
            r1_bi    <= $signed(i_in_item.b_imag[DW-1:0]);
            r1_as_re <= sat_add(n1_x_re);
            r1_as_im <= sat_add(n1_x_im);
        end
    end

    // Stage 2: the six products.
    logic signed [MW-1:0] r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_d_rr, r2_d_ii;
    logic [1:0]           r2_func;
    t_sat                 r2_as_re, r2_as_im;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p_rr  <= MW'(r1_ar) * MW'(r1_br);
            r2_p_ii  <= MW'(r1_ai) * MW'(r1_bi);
            r2_p_ri  <= MW'(r1_ar) * MW'(r1_bi);
            r2_p_ir  <= MW'(r1_ai) * MW'(r1_br);
            r2_d_rr  <= MW'(r1_br) * MW'(r1_br);
            r2_d_ii  <= MW'(r1_bi) * MW'(r1_bi);
            r2_func  <= r1_func;
            r2_as_re <= r1_as_re;
            r2_as_im <= r1_as_im;
        end
    end

    // Stage 3: numerator and denominator sums.
    logic signed [MW:0] r3_x_re, r3_x_im;
    logic [MW-1:0]      r3_den;
    logic [1:0]         r3_func;
    t_sat               r3_as_re, r3_as_im;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r2_func == cau_pkg::FN_DIV) begin
                r3_x_re <= (MW + 1)'(r2_p_rr) + (MW + 1)'(r2_p_ii);
                r3_x_im <= (MW + 1)'(r2_p_ir) - (MW + 1)'(r2_p_ri);
            end else begin
                r3_x_re <= (MW + 1)'(r2_p_rr) - (MW + 1)'(r2_p_ii);
                r3_x_im <= (MW + 1)'(r2_p_ri) + (MW + 1)'(r2_p_ir);
            end
            r3_den   <= r2_d_rr[MW-1:0] + r2_d_ii[MW-1:0];
            r3_func  <= r2_func;
            r3_as_re <= r2_as_re;
            r3_as_im <= r2_as_im;
        end
    end

    // Stage 4: sign and magnitude; the multiply result is finished here.
    logic [MW-1:0] r4_mag_re, r4_mag_im;
    t_side         r4_sd;
    logic          n4_neg_re, n4_neg_im;
    logic [MW-1:0] n4_mag_re, n4_mag_im;

    always_comb begin
        logic [MW:0] t_re, t_im;
        n4_neg_re = r3_x_re[MW];
        n4_neg_im = r3_x_im[MW];
        t_re      = n4_neg_re ? -r3_x_re : r3_x_re;
        t_im      = n4_neg_im ? -r3_x_im : r3_x_im;
        n4_mag_re = t_re[MW-1:0];
        n4_mag_im = t_im[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mag_re       <= n4_mag_re;
            r4_mag_im       <= n4_mag_im;
            r4_sd.func      <= r3_func;
            r4_sd.as_re     <= r3_as_re;
            r4_sd.as_im     <= r3_as_im;
            r4_sd.mu_re     <= sat_mag(n4_neg_re, n4_mag_re >> FRAC_BITS);
            r4_sd.mu_im     <= sat_mag(n4_neg_im, n4_mag_im >> FRAC_BITS);
            r4_sd.neg_re    <= n4_neg_re;
            r4_sd.neg_im    <= n4_neg_im;
            r4_sd.dz        <= (r3_den == '0);
            r4_sd.dov_re    <= 1'b0;
            r4_sd.dov_im    <= 1'b0;
            r4_sd.den       <= r3_den;
        end
    end

    // Stage 5: divider setup. The bits of the scaled numerator above the
    // quotient width must stay below the divisor, else the quotient saturates.
    logic [MW-1:0] r_rem_re [0:QW];
    logic [MW-1:0] r_rem_im [0:QW];
    logic [QW-1:0] r_low_re [0:QW];
    logic [QW-1:0] r_low_im [0:QW];
    logic [QW-1:0] r_quo_re [0:QW];
    logic [QW-1:0] r_quo_im [0:QW];
    t_side         r_sd     [0:QW];

    logic [DDW-1:0] n5_d_re, n5_d_im, n5_hi_re, n5_hi_im, n5_den;
    t_side          n5_sd;

    always_comb begin
        n5_d_re  = {r4_mag_re, {FRAC_BITS{1'b0}}};
        n5_d_im  = {r4_mag_im, {FRAC_BITS{1'b0}}};
        n5_hi_re = n5_d_re >> QW;
        n5_hi_im = n5_d_im >> QW;
        n5_den   = DDW'(r4_sd.den);
        n5_sd        = r4_sd;
        n5_sd.dov_re = (n5_hi_re >= n5_den);
        n5_sd.dov_im = (n5_hi_im >= n5_den);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem_re[0]     <= n5_hi_re[MW-1:0];
            r_rem_im[0]     <= n5_hi_im[MW-1:0];
            r_low_re[0]     <= n5_d_re[QW-1:0];
            r_low_im[0]     <= n5_d_im[QW-1:0];
            r_quo_re[0]     <= '0;
            r_quo_im[0]     <= '0;
            r_sd[0]         <= n5_sd;
        end
    end

    // Restoring divider: one quotient bit per stage.
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [MW:0] t_re, t_im;
        logic        ge_re, ge_im;
        logic [MW:0] d_re, d_im;

        always_comb begin
            t_re  = {r_rem_re[k], r_low_re[k][QW-1]};
            t_im  = {r_rem_im[k], r_low_im[k][QW-1]};
            ge_re = (t_re >= {1'b0, r_sd[k].den});
            ge_im = (t_im >= {1'b0, r_sd[k].den});
            d_re  = ge_re ? t_re - {1'b0, r_sd[k].den} : t_re;
            d_im  = ge_im ? t_im - {1'b0, r_sd[k].den} : t_im;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem_re[k+1] <= d_re[MW-1:0];
                r_rem_im[k+1] <= d_im[MW-1:0];
                r_low_re[k+1] <= r_low_re[k] << 1;
                r_low_im[k+1] <= r_low_im[k] << 1;
                r_quo_re[k+1] <= {r_quo_re[k][QW-2:0], ge_re};
                r_quo_im[k+1] <= {r_quo_im[k][QW-2:0], ge_im};
                r_sd[k+1]     <= r_sd[k];
            end
        end
    end

    // Output register: pick the result for the operation.
    t_side              fs;
    t_sat               n_re, n_im;
    logic               n_dz;
    cau_pkg::t_out_item r_out;

    assign fs = r_sd[QW];

    always_comb begin
        n_dz = 1'b0;
        unique case (fs.func)
            cau_pkg::FN_ADD, cau_pkg::FN_SUB: begin
                n_re = fs.as_re;
                n_im = fs.as_im;
            end
            cau_pkg::FN_MUL: begin
                n_re = fs.mu_re;
                n_im = fs.mu_im;
            end
            default: begin
                if (fs.dz) begin
                    n_re = '0;
                    n_im = '0;
                    n_dz = 1'b1;
                end else begin
                    n_re = sat_mag(fs.neg_re, fs.dov_re ? '1 : MW'(r_quo_re[QW]));
                    n_im = sat_mag(fs.neg_im, fs.dov_im ? '1 : MW'(r_quo_im[QW]));
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.res_real    <= 32'($signed(n_re.v));
            r_out.res_imag    <= 32'($signed(n_im.v));
            r_out.overflow    <= n_re.ov || n_im.ov;
            r_out.div_by_zero <= n_dz;
        end
    end

    assign o_out_item = r_out;

    // A divide by zero never reports overflow and always gives zero parts.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.div_by_zero |->
            !o_out_item.overflow && o_out_item.res_real == '0 &&
            o_out_item.res_imag == '0)
        else $error("divide by zero result not clean");

    // A stalled pipeline keeps every item in place.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // An accepted item occupies the first stage on the next cycle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    // A result that waits at the output stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while waiting");

endmodule

`default_nettype wire

// ===== bench/complex_arith_unit_tb.sv =====
`timescale 1ns / 1ps

module complex_arith_unit_tb;

    localparam int LATENCY = 40;

    class cplx_scoreboard;
        cau_pkg::t_out_item pending[$];
        int mismatches;

        // Saturation of a wide signed value to the signed 32-bit range.
        function logic [31:0] clamp32(logic signed [127:0] v, ref bit ovf);
            if (v > 128'sd2147483647) begin
                ovf = 1;
                return 32'h7fffffff;
            end
            if (v < -128'sd2147483648) begin
                ovf = 1;
                return 32'h80000000;
            end
            return v[31:0];
        endfunction

        // Truncating divide of num * 2^16 by den, toward zero.
        function logic signed [127:0] scaled_quot(logic signed [127:0] num,
                                                  logic signed [127:0] den);
            logic signed [127:0] mag;
            mag = (num < 0) ? -num : num;
            mag = (mag <<< 16) / den;
            return (num < 0) ? -mag : mag;
        endfunction

        function logic signed [127:0] trunc16(logic signed [127:0] v);
            logic signed [127:0] mag;
            mag = (v < 0) ? -v : v;
            mag = mag >>> 16;
            return (v < 0) ? -mag : mag;
        endfunction

        function void note_input(cau_pkg::t_in_item it);
            logic signed [127:0] ar, ai, br, bi, rr, ri, den;
            cau_pkg::t_out_item r;
            bit ovf;
            ar = $signed(it.a_real);
            ai = $signed(it.a_imag);
            br = $signed(it.b_real);
            bi = $signed(it.b_imag);
            ovf = 0;
            r = '0;
            rr = 0;
            ri = 0;
            case (cau_pkg::t_func'(it.func))
                cau_pkg::FN_ADD: begin rr = ar + br; ri = ai + bi; end
                cau_pkg::FN_SUB: begin rr = ar - br; ri = ai - bi; end
                cau_pkg::FN_MUL: begin
                    rr = trunc16(ar * br - ai * bi);
                    ri = trunc16(ar * bi + ai * br);
                end
                cau_pkg::FN_DIV: begin
                    den = br * br + bi * bi;
                    if (den == 0) r.div_by_zero = 1;
                    else begin
                        rr = scaled_quot(ar * br + ai * bi, den);
                        ri = scaled_quot(ai * br - ar * bi, den);
                    end
                end
            endcase
            r.res_real = clamp32(rr, ovf);
            r.res_imag = clamp32(ri, ovf);
            r.overflow = ovf;
            pending.push_back(r);
        endfunction

        function void check_result(cau_pkg::t_out_item got);
            cau_pkg::t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.res_real !== want.res_real || got.res_imag !== want.res_imag ||
                got.overflow !== want.overflow || got.div_by_zero !== want.div_by_zero) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h %h ovf=%b dz=%b, got %h %h ovf=%b dz=%b",
                             want.res_real, want.res_imag, want.overflow, want.div_by_zero,
                             got.res_real, got.res_imag, got.overflow, got.div_by_zero);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic in_valid = 0;
    logic out_ready = 0;
    cau_pkg::t_in_item in_item = '0;
    logic o_in_ready, o_out_valid;
    cau_pkg::t_out_item o_out_item;
    cplx_scoreboard sb;
    int accepted = 0;

    always #1 i_clk = ~i_clk;

    complex_arith_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_item(in_item),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_item(o_out_item)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) begin
            sb.note_input(in_item);
            accepted++;
        end
        if (i_rst_n && o_out_valid && out_ready) sb.check_result(o_out_item);
    end

    // Receiver stall pattern: each cycle the receiver is either held ready or ready at random.
    always @(posedge i_clk) begin
        int ph;
        ph = ($urandom_range(0, 255) + accepted / 64) % 4;
        if (!i_rst_n) out_ready <= 0;
        else if (ph == 0) out_ready <= 1;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    function logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4, 5: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(cau_pkg::t_in_item it);
        in_item <= it;
        in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        cau_pkg::t_in_item it;
        logic [31:0] ext[4];
        int burst;
        ext = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: every operation against the field extremes.
        for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < 4; k++) begin
                it.func = f[1:0];
                it.a_real = ext[k];
                it.a_imag = ext[(k + 1) % 4];
                it.b_real = ext[(k + 2) % 4];
                it.b_imag = ext[(k + 3) % 4];
                send_item(it);
            end
        end
        // Divide by zero, a tiny divisor that overflows the quotient, and an ordinary divide.
        it = '{cau_pkg::FN_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0};
        send_item(it);
        it = '{cau_pkg::FN_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0};
        send_item(it);
        it = '{cau_pkg::FN_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00010000};
        send_item(it);
        idle_gap(3);
        while (accepted < 680) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                it.func = 2'($urandom_range(0, 3));
                it.a_real = pick_operand();
                it.a_imag = pick_operand();
                it.b_real = pick_operand();
                it.b_imag = pick_operand();
                send_item(it);
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
